// File: src/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types and constants for the nearest palette colour quantiser.
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int CH_W     = 8;
    localparam int ERR_W    = 16;
    localparam int DIST_W   = 2 * CH_W + 2;
    localparam int SIZE_W   = 9;
    localparam int IDX_W    = 8;
    localparam int SCAN_CAP = 256;

    localparam int DEF_PALETTE_DEPTH = 256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

endpackage

// File: src/pnc_mem.sv
// ----------------------------------------------------------------------------
// pnc_mem
// Palette store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pnc_mem
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
    parameter int AW            = $clog2(PALETTE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rgb          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rgb          o_rdata
);

    t_rgb r_mem [PALETTE_DEPTH];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pnc_dist.sv
// ----------------------------------------------------------------------------
// pnc_dist
// Distance unit: squared Euclidean distance of one palette entry per
// cycle, registered, with the entry's index and colour carried alongside.
// ----------------------------------------------------------------------------
module pnc_dist
    import pnc_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [AW-1:0]     i_index,
    input  t_rgb              i_color,
    input  t_rgb              i_pixel,
    output logic              o_valid,
    output logic [AW-1:0]     o_index,
    output t_rgb              o_color,
    output logic [DIST_W-1:0] o_dist
);

    logic [CH_W-1:0]     d_red;
    logic [CH_W-1:0]     d_green;
    logic [CH_W-1:0]     d_blue;
    logic [2*CH_W-1:0]   sq_red;
    logic [2*CH_W-1:0]   sq_green;
    logic [2*CH_W-1:0]   sq_blue;
    logic [DIST_W-1:0]   n_dist;
    logic                r_valid;
    logic [AW-1:0]       r_index;
    t_rgb                r_color;
    logic [DIST_W-1:0]   r_dist;

    always_comb begin
        d_red    = (i_pixel.red > i_color.red) ? i_pixel.red - i_color.red
                                               : i_color.red - i_pixel.red;
        d_green  = (i_pixel.green > i_color.green) ? i_pixel.green - i_color.green
                                                   : i_color.green - i_pixel.green;
        d_blue   = (i_pixel.blue > i_color.blue) ? i_pixel.blue - i_color.blue
                                                 : i_color.blue - i_pixel.blue;
        sq_red   = {{CH_W{1'b0}}, d_red} * {{CH_W{1'b0}}, d_red};
        sq_green = {{CH_W{1'b0}}, d_green} * {{CH_W{1'b0}}, d_green};
        sq_blue  = {{CH_W{1'b0}}, d_blue} * {{CH_W{1'b0}}, d_blue};
        n_dist   = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= i_index;
        r_color <= i_color;
        r_dist  <= n_dist;
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_color = r_color;
    assign o_dist  = r_dist;

endmodule

// File: src/pnc_err.sv
// ----------------------------------------------------------------------------
// pnc_err
// Carried colour error: adjusts and clamps the incoming pixel, and folds the
// pixel minus the chosen colour back into the saturating error registers.
// ----------------------------------------------------------------------------
module pnc_err
    import pnc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_rgb i_pixel,
    input  t_rgb i_chosen,
    input  logic i_update,
    output t_rgb o_adjusted
);

    logic signed [ERR_W-1:0] r_err_red;
    logic signed [ERR_W-1:0] r_err_green;
    logic signed [ERR_W-1:0] r_err_blue;
    logic signed [ERR_W-1:0] n_err_red;
    logic signed [ERR_W-1:0] n_err_green;
    logic signed [ERR_W-1:0] n_err_blue;

    function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] p,
                                                 input logic signed [ERR_W-1:0] e);
        logic signed [ERR_W:0] s;
        s = $signed({{(ERR_W-CH_W+1){1'b0}}, p}) + $signed({e[ERR_W-1], e});
        if (s < 0) begin
            clamp_ch = '0;
        end else if (s > $signed((ERR_W+1)'(255))) begin
            clamp_ch = CH_W'(8'hff);
        end else begin
            clamp_ch = s[CH_W-1:0];
        end
    endfunction

    function automatic logic signed [ERR_W-1:0] carry(input logic signed [ERR_W-1:0] e,
                                                      input logic [CH_W-1:0] p,
                                                      input logic [CH_W-1:0] c);
        logic signed [ERR_W+1:0] s;
        s = $signed({{2{e[ERR_W-1]}}, e}) + $signed({{(ERR_W-CH_W+2){1'b0}}, p})
          - $signed({{(ERR_W-CH_W+2){1'b0}}, c});
        if (s > $signed((ERR_W+2)'(32767))) begin
            carry = ERR_W'(16'sh7fff);
        end else if (s < -$signed((ERR_W+2)'(32768))) begin
            carry = ERR_W'(16'sh8000);
        end else begin
            carry = s[ERR_W-1:0];
        end
    endfunction

    always_comb begin
        o_adjusted.red   = clamp_ch(i_pixel.red,   r_err_red);
        o_adjusted.green = clamp_ch(i_pixel.green, r_err_green);
        o_adjusted.blue  = clamp_ch(i_pixel.blue,  r_err_blue);
        n_err_red   = carry(r_err_red,   i_pixel.red,   i_chosen.red);
        n_err_green = carry(r_err_green, i_pixel.green, i_chosen.green);
        n_err_blue  = carry(r_err_blue,  i_pixel.blue,  i_chosen.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_red   <= '0;
            r_err_green <= '0;
            r_err_blue  <= '0;
        end else if (i_update) begin
            r_err_red   <= n_err_red;
            r_err_green <= n_err_green;
            r_err_blue  <= n_err_blue;
        end
    end

endmodule

// File: src/palette_nearest_color_with_error_carry.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_with_error_carry
// Maps RGB pixels to the index of the nearest palette colour, carrying the
// quantisation error from pixel to pixel.
// ----------------------------------------------------------------------------
// Channel   Signals                                         Flow
// item      i_start / o_busy, i_cmd, i_entry_index, RGB    taken on start & !busy
// result    o_valid, o_palette_index                       one-cycle strobe
// config    i_cfg_we, i_cfg_wdata (palette size)           written on i_cfg_we
//
// A load item writes its palette entry and leaves the block idle.
// A pixel item keeps o_busy high through PREP, SCAN and DRAIN, the scan
// reading N entries, one a cycle; the strobe comes in the cycle after, when
// the next item may already be taken. N is the palette size, zero as one,
// capped at SCAN_MAX. Reset clears the carried errors and sets the palette
// size to one; the palette is empty until loaded. Results cannot be held off.
// ----------------------------------------------------------------------------
module palette_nearest_color_with_error_carry
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cmd,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_palette_index
);

    localparam int AW       = $clog2(PALETTE_DEPTH);
    localparam int CNT_W    = AW + 1;
    localparam int SCAN_MAX = (PALETTE_DEPTH < SCAN_CAP) ? PALETTE_DEPTH : SCAN_CAP;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [AW-1:0]     r_addr;
    logic              r_v1;
    logic [AW-1:0]     r_i1;
    t_rgb              r_pixel;
    t_rgb              r_adj;
    t_rgb              adjusted;
    t_rgb              rd_color;
    logic              dist_valid;
    logic [AW-1:0]     dist_index;
    t_rgb              dist_color;
    logic [DIST_W-1:0] dist_value;
    logic [AW-1:0]     r_best;
    logic [DIST_W-1:0] r_best_dist;
    t_rgb              r_best_color;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic              accept;
    logic              load_we;
    logic              finish;
    t_rgb              in_color;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign in_color = '{red: i_red, green: i_green, blue: i_blue};
    assign load_we  = accept && (i_cmd == CMD_LOAD)
                   && (int'(i_entry_index) < PALETTE_DEPTH);
    assign finish   = (r_state == ST_DRAIN) && !r_v1 && !dist_valid;

    // Scan count: zero counts as one, and it saturates at SCAN_MAX, the smaller of the store depth and SCAN_CAP.
    always_comb begin
        int v_cnt;
        v_cnt = (r_size == '0) ? 1 : int'(r_size);
        if (v_cnt > SCAN_MAX) begin
            v_cnt = SCAN_MAX;
        end
        n_count = CNT_W'(v_cnt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_PIXEL)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (CNT_W'(r_addr) == r_count - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_RESET;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= (r_state == ST_SCAN);
            r_out_valid <= finish;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= in_color;
            r_count <= n_count;
        end
        if (r_state == ST_PREP) begin
            r_adj  <= adjusted;
            r_addr <= '0;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + AW'(1);
        end
        r_i1 <= r_addr;
        // Only a strictly smaller distance displaces the best, so ties keep
        // the lowest index.
        if (dist_valid && (dist_index == '0 || dist_value < r_best_dist)) begin
            r_best       <= dist_index;
            r_best_dist  <= dist_value;
            r_best_color <= dist_color;
        end
        if (finish) begin
            r_out_index <= IDX_W'(r_best);
        end
    end

    pnc_mem #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (in_color),
        .i_raddr (r_addr),
        .o_rdata (rd_color)
    );

    pnc_dist #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_index (r_i1),
        .i_color (rd_color),
        .i_pixel (r_adj),
        .o_valid (dist_valid),
        .o_index (dist_index),
        .o_color (dist_color),
        .o_dist  (dist_value)
    );

    pnc_err u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pixel    (r_pixel),
        .i_chosen   (r_best_color),
        .i_update   (finish),
        .o_adjusted (adjusted)
    );

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_palette_index = r_out_index;

endmodule

// File: src/pnc_chk.sv
// ----------------------------------------------------------------------------
// pnc_chk
// Port-level checks on the quantiser's command and result timing.
// ----------------------------------------------------------------------------
module pnc_chk
    import pnc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_cmd,
    input logic o_busy,
    input logic o_valid
);

    // A result strobe lasts a single cycle and never comes twice in a row.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A result is only ever shown once the block has gone idle after a scan.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && $past(o_busy)))
        else $error("result strobe without a preceding busy period");

    // A pixel item occupies the block.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_PIXEL) |=> o_busy)
        else $error("pixel item taken but block not busy");

    // A load item completes at once and produces no result.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_LOAD) |=> (!o_busy && !o_valid))
        else $error("load item left the block busy or produced a result");

endmodule

bind palette_nearest_color_with_error_carry pnc_chk u_pnc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_cmd   (i_cmd),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
